// ----- rtl/ctf_pkg.sv -----
package ctf_pkg;

  localparam int CORDIC_STEPS_DEF = 20;
  localparam int ATAN_ENTRIES     = 28;
  localparam int ATAN_IDX_W       = 5;
  localparam int ATAN_W           = 24;

  localparam int SAMPLE_W   = 16;
  localparam int ANGLE_W    = 32;
  localparam int IN_DATA_W  = 3 * SAMPLE_W;
  localparam int OUT_DATA_W = 2 * ANGLE_W;

  // CORDIC vector and angle widths
  localparam int CV_W = 34;
  localparam int Z_W  = 28;
  localparam logic signed [Z_W-1:0] PI_Q24 = 28'sd52707179;

  // shared multiplier operand widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // full scale times pi/180 in Q40, split in two halves for the multiplier
  localparam int GAIN_W      = 46;
  localparam int GAIN_HALF_W = 23;
  localparam logic [63:0] DEG2RAD_Q40 = 64'd19190098069;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_WEIGHT   = 2'd2;

  localparam int RANGE_W  = 2;
  localparam int PERIOD_W = 24;
  localparam int WEIGHT_W = 17;
  localparam logic [RANGE_W-1:0]  RANGE_RST  = 2'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd16777;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd64225;

  function automatic logic [ATAN_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 24'd13176795;
      5'd1:    v = 24'd7778716;
      5'd2:    v = 24'd4110060;
      5'd3:    v = 24'd2086331;
      5'd4:    v = 24'd1047214;
      5'd5:    v = 24'd524117;
      5'd6:    v = 24'd262123;
      5'd7:    v = 24'd131069;
      5'd8:    v = 24'd65536;
      5'd9:    v = 24'd32768;
      5'd10:   v = 24'd16384;
      5'd11:   v = 24'd8192;
      5'd12:   v = 24'd4096;
      5'd13:   v = 24'd2048;
      5'd14:   v = 24'd1024;
      5'd15:   v = 24'd512;
      5'd16:   v = 24'd256;
      5'd17:   v = 24'd128;
      5'd18:   v = 24'd64;
      5'd19:   v = 24'd32;
      5'd20:   v = 24'd16;
      5'd21:   v = 24'd8;
      5'd22:   v = 24'd4;
      5'd23:   v = 24'd2;
      5'd24:   v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // each arm is a product of constants, so the selection is a plain table
  function automatic logic [GAIN_W-1:0] rate_gain(input logic [RANGE_W-1:0] sel);
    logic [GAIN_W-1:0] g;
    unique case (sel)
      2'd0: g = GAIN_W'(64'd250 * DEG2RAD_Q40);
      2'd1: g = GAIN_W'(64'd500 * DEG2RAD_Q40);
      2'd2: g = GAIN_W'(64'd1000 * DEG2RAD_Q40);
      2'd3: g = GAIN_W'(64'd2000 * DEG2RAD_Q40);
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/ctf_mul.sv -----
module ctf_mul (
  input  logic                                 clk,
  input  logic signed [ctf_pkg::MUL_A_W-1:0]   a,
  input  logic signed [ctf_pkg::MUL_B_W-1:0]   b,
  output logic signed [ctf_pkg::MUL_P_W-1:0]   p
);
  import ctf_pkg::*;

  logic signed [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

// ----- rtl/ctf_cordic.sv -----
module ctf_cordic #(
  parameter int STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0] accel_y,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0] accel_z,
  output logic                                busy,
  output logic signed [ctf_pkg::Z_W-1:0]      z
);
  import ctf_pkg::*;

  localparam int STEPS_EFF = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
  localparam int CNT_W     = $clog2(STEPS_EFF);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS_EFF - 1);
  localparam int PRESCALE  = 14;

  logic                   busy_r, busy_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic signed [CV_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;

  logic signed [CV_W-1:0] ay_s, az_s, xs, ys;
  logic signed [Z_W-1:0]  step_angle;

  assign ay_s = CV_W'(accel_y) <<< PRESCALE;
  assign az_s = CV_W'(accel_z) <<< PRESCALE;
  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;
  assign step_angle = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q24(ATAN_IDX_W'(cnt_r))});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      // x = -z; a negative x is folded into the right half plane, starting at +/-pi
      if (accel_z > 16'sd0) begin
        x_nxt = az_s;
        y_nxt = -ay_s;
        z_nxt = accel_y[SAMPLE_W-1] ? -PI_Q24 : PI_Q24;
      end else begin
        x_nxt = -az_s;
        y_nxt = ay_s;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + step_angle;
      end else if (y_r < 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - step_angle;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign busy = busy_r;
  assign z    = z_r;

`ifndef ASSERT_OFF
  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == '0)
    else $error("cordic did not arm on start");

  a_last_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == LAST |=> !busy_r)
    else $error("cordic ran past its last step");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= LAST)
    else $error("cordic step count out of range");
`endif

endmodule

// ----- rtl/complementary_tilt_filter_core.sv -----
// Channel   Dir  Handshake          Payload (low bit up)
// in_       in   in_tvalid/tready   in_tdata: gyro_rate_raw, accel_y_raw, accel_z_raw
// out_      out  out_tvalid/tready  out_tdata: tilt_angle, tilt_rate
// cfg_      in   cfg_we             cfg_index, cfg_data
//
// One sample is processed at a time; its pace is set by the CORDIC
// iterations that run while the shared multiplier works out the rate and gyro terms.
// in_tready is high only while idle; a waiting result does not block the next request.
// A stalled output holds the sequencer in its final step until out_tready.
// rst_n (synchronous) clears angle and rate state and loads the register defaults.
module complementary_tilt_filter_core #(
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // gyro_rate_raw [15:0], accel_y_raw [31:16], accel_z_raw [47:32]
  input  logic [ctf_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tilt_angle [31:0], tilt_rate [63:32]
  output logic [ctf_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic [ctf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ctf_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RLO   = 4'd1;
  localparam logic [3:0] ST_RHI   = 4'd2;
  localparam logic [3:0] ST_GYR   = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_WAITC = 4'd5;
  localparam logic [3:0] ST_BLW   = 4'd6;
  localparam logic [3:0] ST_BLA   = 4'd7;
  localparam logic [3:0] ST_BLS   = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  localparam int ACC_W     = 62;
  localparam int S_W       = 45;
  localparam int Q_W       = 30;
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int BSH_W     = 46;
  localparam int DIV_SH    = 15;
  localparam int DIV_CNT_W = 3;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd4;

  localparam logic [S_W-1:0] DIV_MASK = S_W'(32'h7fff);
  localparam logic [S_W-1:0] DIV_ONE  = S_W'(32'd32767);
  localparam logic signed [ACC_W-1:0]   RATE_HALF  = ACC_W'(64'd1073709056);
  localparam logic signed [ACC_W-1:0]   BLEND_HALF = ACC_W'(64'd32768);
  localparam logic signed [MUL_P_W-1:0] GYRO_HALF  = MUL_P_W'(64'd8388608);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
  localparam logic signed [ANGLE_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [ANGLE_W-1:0] SAT_MIN = 32'sh80000000;

  logic [3:0]                state_r, state_nxt;
  logic [RANGE_W-1:0]        range_r, range_nxt;
  logic [PERIOD_W-1:0]       period_r, period_nxt;
  logic [WEIGHT_W-1:0]       weight_r, weight_nxt;
  logic signed [ANGLE_W-1:0] angle_estimate_r, angle_estimate_nxt;
  logic signed [ANGLE_W-1:0] previous_rate_r, previous_rate_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [MAG_W-1:0]          mag_r, mag_nxt;
  logic                      gpos_r, gpos_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [S_W-1:0]            s_r, s_nxt;
  logic [Q_W-1:0]            q_r, q_nxt;
  logic [DIV_CNT_W-1:0]      div_cnt_r, div_cnt_nxt;
  logic signed [MUL_A_W-1:0] gyro_r, gyro_nxt;

  logic signed [SAMPLE_W-1:0] g_in, ay_in, az_in;
  logic signed [MAG_W-1:0]    g_ext;
  logic                       in_accept, fin_fire;
  logic [GAIN_W-1:0]          gain;
  logic [WEIGHT_W-1:0]        w_eff, w_rest;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [MUL_P_W-1:0]  gr_sum;
  logic signed [ACC_W-1:0]    rate_sum;
  logic [S_W-1:0]             s_hi, s_red;
  logic signed [BSH_W-1:0]    bsh;
  logic                       ovf;
  logic signed [ANGLE_W-1:0]  angle_new, rate_new, q_ext;
  logic                       cordic_busy;
  logic signed [Z_W-1:0]      cordic_z;

  assign g_in  = in_tdata[SAMPLE_W-1:0];
  assign ay_in = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign az_in = in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
  assign g_ext = MAG_W'(g_in);

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign fin_fire  = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  assign gain   = rate_gain(range_r);
  assign w_eff  = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign w_rest = WEIGHT_ONE - w_eff;

  // q = floor(s / (2^15 - 1)) by folding 15-bit digits: 2^15 = 1 mod divisor
  assign s_hi  = s_r >> DIV_SH;
  assign s_red = s_hi + (s_r & DIV_MASK);

  assign gr_sum   = mul_p + GYRO_HALF;
  assign rate_sum = acc_r + (ACC_W'(mul_p) <<< GAIN_HALF_W);

  assign bsh       = BSH_W'(acc_r >>> 16);
  assign ovf       = bsh[BSH_W-1:ANGLE_W-1] != {(BSH_W-ANGLE_W+1){bsh[BSH_W-1]}};
  assign angle_new = ovf ? (bsh[BSH_W-1] ? SAT_MIN : SAT_MAX) : bsh[ANGLE_W-1:0];
  assign q_ext     = $signed({{(ANGLE_W-Q_W){1'b0}}, q_r});
  assign rate_new  = gpos_r ? -q_ext : q_ext;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_RLO: begin
        mul_a = $signed({{(MUL_A_W-MAG_W){1'b0}}, mag_r});
        mul_b = $signed({{(MUL_B_W-GAIN_HALF_W){1'b0}}, gain[GAIN_HALF_W-1:0]});
      end
      ST_RHI: begin
        mul_a = $signed({{(MUL_A_W-MAG_W){1'b0}}, mag_r});
        mul_b = $signed({{(MUL_B_W-GAIN_HALF_W){1'b0}}, gain[GAIN_W-1:GAIN_HALF_W]});
      end
      ST_GYR: begin
        mul_a = MUL_A_W'(previous_rate_r);
        mul_b = $signed({{(MUL_B_W-PERIOD_W){1'b0}}, period_r});
      end
      ST_BLW: begin
        mul_a = gyro_r;
        mul_b = $signed({{(MUL_B_W-WEIGHT_W){1'b0}}, w_eff});
      end
      ST_BLA: begin
        mul_a = MUL_A_W'(cordic_z);
        mul_b = $signed({{(MUL_B_W-WEIGHT_W){1'b0}}, w_rest});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt          = state_r;
    range_nxt          = range_r;
    period_nxt         = period_r;
    weight_nxt         = weight_r;
    angle_estimate_nxt = angle_estimate_r;
    previous_rate_nxt  = previous_rate_r;
    out_valid_nxt      = out_valid_r && !out_tready;
    mag_nxt            = mag_r;
    gpos_nxt           = gpos_r;
    acc_nxt            = acc_r;
    s_nxt              = s_r;
    q_nxt              = q_r;
    div_cnt_nxt        = div_cnt_r;
    gyro_nxt           = gyro_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GYRO_RANGE:    range_nxt  = cfg_data[RANGE_W-1:0];
        CFG_SAMPLE_PERIOD: period_nxt = cfg_data[PERIOD_W-1:0];
        CFG_GYRO_WEIGHT:   weight_nxt = cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          mag_nxt   = g_in[SAMPLE_W-1] ? MAG_W'(-g_ext) : MAG_W'(g_ext);
          gpos_nxt  = !g_in[SAMPLE_W-1] && (g_in != '0);
          state_nxt = ST_RLO;
        end
      end
      ST_RLO: state_nxt = ST_RHI;
      ST_RHI: begin
        acc_nxt   = ACC_W'(mul_p) + RATE_HALF;
        state_nxt = ST_GYR;
      end
      ST_GYR: begin
        s_nxt       = S_W'(rate_sum >>> 16);
        q_nxt       = '0;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == '0) begin
          gyro_nxt = MUL_A_W'(gr_sum >>> 24) + MUL_A_W'(angle_estimate_r);
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r != DIV_LAST) begin
          s_nxt = s_red;
          q_nxt = q_r + Q_W'(s_hi);
        end else begin
          // remainder equal to the divisor counts once more
          if (s_r == DIV_ONE) begin
            q_nxt = q_r + 1'b1;
            s_nxt = '0;
          end
          state_nxt = ST_WAITC;
        end
      end
      ST_WAITC: begin
        if (!cordic_busy) begin
          state_nxt = ST_BLW;
        end
      end
      ST_BLW: state_nxt = ST_BLA;
      ST_BLA: begin
        acc_nxt   = ACC_W'(mul_p);
        state_nxt = ST_BLS;
      end
      ST_BLS: begin
        acc_nxt   = acc_r + ACC_W'(mul_p) + BLEND_HALF;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_fire) begin
          angle_estimate_nxt = angle_new;
          previous_rate_nxt  = rate_new;
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      range_r          <= RANGE_RST;
      period_r         <= PERIOD_RST;
      weight_r         <= WEIGHT_RST;
      angle_estimate_r <= '0;
      previous_rate_r  <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      range_r          <= range_nxt;
      period_r         <= period_nxt;
      weight_r         <= weight_nxt;
      angle_estimate_r <= angle_estimate_nxt;
      previous_rate_r  <= previous_rate_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    gpos_r    <= gpos_nxt;
    acc_r     <= acc_nxt;
    s_r       <= s_nxt;
    q_r       <= q_nxt;
    div_cnt_r <= div_cnt_nxt;
    gyro_r    <= gyro_nxt;
  end

  ctf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ctf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_accept),
    .accel_y (ay_in),
    .accel_z (az_in),
    .busy    (cordic_busy),
    .z       (cordic_z)
  );

  // the state registers double as the output payload
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {previous_rate_r, angle_estimate_r};

`ifndef ASSERT_OFF
  a_cordic_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_busy |-> state_r != ST_IDLE)
    else $error("cordic running while sequencer idle");

  a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_RLO)
    else $error("accepted request did not start the sequence");

  a_div_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAITC |-> s_r < DIV_ONE)
    else $error("rate division left a remainder not below divisor");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result posted outside final step");
`endif

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctf_pkg::*;

  localparam int CORDIC_ITERS = CORDIC_STEPS_DEF;
  localparam int ARCTAN_LEN = 28;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint HALF_TURN_Q24 = 64'sd52707179;
  localparam longint unsigned DEG_TO_RAD_Q40 = 64'd19190098069;
  localparam longint unsigned RATE_DIVISOR = 64'd2147418112;
  // index 3 decodes to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // gyro sign bias for random samples
  localparam int BIAS_NONE = 0;
  localparam int BIAS_UP = 1;
  localparam int BIAS_DOWN = 2;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] rate;
    logic signed [ANGLE_W-1:0] angle;
  } tilt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [IN_DATA_W-1:0] pending_samples[$];
  tilt_t expected_tilt[$];
  logic in_fire = 1'b0;
  logic steady = 1'b0;
  int mismatch_count = 0;
  int samples_checked = 0;
  int settings_count = 1;
  int unsigned cycle_count = 0;

  // filter state and register copy
  logic [RANGE_W-1:0] m_range;
  logic [PERIOD_W-1:0] m_period;
  logic [WEIGHT_W-1:0] m_weight;
  logic signed [ANGLE_W-1:0] est_angle;
  logic signed [ANGLE_W-1:0] held_rate;

  longint arctan_tab [0:ARCTAN_LEN-1] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0
  };

  complementary_tilt_filter_core #(.CORDIC_STEPS(CORDIC_ITERS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned full_scale_dps(input logic [RANGE_W-1:0] sel);
    case (sel)
      2'd0: return 250;
      2'd1: return 500;
      2'd2: return 1000;
      default: return 2000;
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] clamp_q824(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[ANGLE_W-1:0];
  endfunction

  // atan2(ay, -az), vectoring CORDIC on inputs scaled by 2^14
  function automatic longint accel_angle(input longint ay, input longint az);
    longint x, y, z, xs, ys;
    int n, i;
    x = -az * 16384;
    y = ay * 16384;
    z = 0;
    n = (CORDIC_ITERS > ARCTAN_LEN) ? ARCTAN_LEN : CORDIC_ITERS;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
      x = -x;
      y = -y;
    end
    for (i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_tab[i];
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_tab[i];
      end
    end
    return z;
  endfunction

  task automatic predict_tilt(input logic [IN_DATA_W-1:0] sample);
    longint g, ay, az, rate, gyro_ang, acc_ang, w, blend;
    longint unsigned mag, q;
    tilt_t t;
    g = longint'($signed(sample[15:0]));
    ay = longint'($signed(sample[31:16]));
    az = longint'($signed(sample[47:32]));
    mag = (g < 0) ? -g : g;
    q = (mag * full_scale_dps(m_range) * DEG_TO_RAD_Q40 + RATE_DIVISOR / 2) / RATE_DIVISOR;
    rate = (g > 0) ? -longint'(q) : longint'(q);
    // rate from the previous sample drives this step's integration
    gyro_ang = ((longint'(held_rate) * longint'(m_period)) + 64'sd8388608) >>> 24;
    gyro_ang = gyro_ang + longint'(est_angle);
    acc_ang = accel_angle(ay, az);
    w = (m_weight > 17'd65536) ? 64'sd65536 : longint'(m_weight);
    blend = (w * gyro_ang + (64'sd65536 - w) * acc_ang + 64'sd32768) >>> 16;
    est_angle = clamp_q824(blend);
    held_rate = clamp_q824(rate);
    t.angle = est_angle;
    t.rate = held_rate;
    expected_tilt.push_back(t);
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  // monitor: register copy, prediction on each request, result check
  always @(posedge clk) begin
    tilt_t want;
    if (!rst_n) begin
      m_range = RANGE_RST;
      m_period = PERIOD_RST;
      m_weight = WEIGHT_RST;
      est_angle = '0;
      held_rate = '0;
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GYRO_RANGE: m_range = cfg_data[RANGE_W-1:0];
          CFG_SAMPLE_PERIOD: m_period = cfg_data[PERIOD_W-1:0];
          CFG_GYRO_WEIGHT: m_weight = cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_tilt(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_tilt.size() == 0) begin
          report_mismatch("result with none pending, tilt_angle", out_tdata[31:0], 0);
        end else begin
          want = expected_tilt.pop_front();
          samples_checked++;
          if (out_tdata[31:0] !== want.angle)
            report_mismatch("tilt_angle", out_tdata[31:0], want.angle);
          if (out_tdata[63:32] !== want.rate)
            report_mismatch("tilt_rate", out_tdata[63:32], want.rate);
        end
      end
    end
  end

  // driver: request from the pending queue, random gaps on both sides
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 31);
    if (!in_tvalid || in_fire) begin
      if (rst_n && pending_samples.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
        in_tdata <= pending_samples.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_sample(input logic [15:0] g,
                                                       input logic [15:0] ay,
                                                       input logic [15:0] az);
    return {az, ay, g};
  endfunction

  function automatic logic [15:0] pick_field();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      2: return 16'($urandom_range(31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int n, input int bias);
    logic [15:0] g;
    repeat (n) begin
      case (bias)
        BIAS_UP: g = 16'(32'd0 - $urandom_range(1, 32768));
        BIAS_DOWN: g = 16'($urandom_range(1, 32767));
        default: g = pick_field();
      endcase
      pending_samples.push_back(pack_sample(g, pick_field(), pick_field()));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_tvalid || expected_tilt.size() != 0 ||
           !in_tready);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // idle-only register update; junk to the unused index must be ignored
  task automatic set_regs(input logic [CFG_DATA_W-1:0] range, input logic [CFG_DATA_W-1:0] period,
                          input logic [CFG_DATA_W-1:0] weight);
    wait_idle();
    cfg_write(CFG_GYRO_RANGE, range);
    cfg_write(CFG_SAMPLE_PERIOD, period);
    cfg_write(CFG_GYRO_WEIGHT, weight);
    cfg_write(CFG_UNUSED, 24'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_count++;
  endtask

  initial begin
    int k;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, half-turn cases, field extremes, bit patterns
    pending_samples.push_back(pack_sample(16'h0000, 16'h0000, 16'h0000));
    pending_samples.push_back(pack_sample(16'h7FFF, 16'h0000, 16'h0001));
    pending_samples.push_back(pack_sample(16'h8000, 16'hFFFF, 16'h0001));
    pending_samples.push_back(pack_sample(16'h0001, 16'h7FFF, 16'h8000));
    pending_samples.push_back(pack_sample(16'hFFFF, 16'h8000, 16'h7FFF));
    pending_samples.push_back(pack_sample(16'h0000, 16'h7FFF, 16'h0000));
    pending_samples.push_back(pack_sample(16'h0000, 16'h8000, 16'h0000));
    pending_samples.push_back(pack_sample(16'h0000, 16'h0000, 16'h8000));
    pending_samples.push_back(pack_sample(16'h0000, 16'h0000, 16'h7FFF));
    pending_samples.push_back(pack_sample(16'h5555, 16'hAAAA, 16'h5555));
    pending_samples.push_back(pack_sample(16'hAAAA, 16'h5555, 16'hAAAA));
    pending_samples.push_back(pack_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_samples.push_back(pack_sample(16'h7FFF, 16'h0064, 16'hFF9C));
    pending_samples.push_back(pack_sample(16'h8000, 16'hFF9C, 16'hFF9C));
    pending_samples.push_back(pack_sample(16'h8000, 16'h0000, 16'h0000));
    queue_random(40, BIAS_NONE);

    // full range, dt near one second, weight above one: drives saturation both ways
    set_regs(24'd3, 24'hFFFFFF, 24'd131071);
    queue_random(40, BIAS_UP);
    queue_random(40, BIAS_DOWN);

    // zero dt with pure gyro weight: angle only holds
    set_regs(24'd1, 24'd0, 24'd65536);
    queue_random(60, BIAS_NONE);

    // smallest dt, accel only
    set_regs(24'd2, 24'd1, 24'd0);
    queue_random(150, BIAS_NONE);

    // nominal settings with no gaps on either side
    set_regs(24'd0, 24'd16777, 24'd64225);
    steady = 1'b1;
    queue_random(250, BIAS_NONE);
    wait_idle();
    steady = 1'b0;

    for (k = 0; k < 5; k++) begin
      set_regs({22'($urandom), 2'(k)},
               (k % 2 == 0) ? 24'($urandom_range(1, 24'hFFFFFF)) : 24'($urandom_range(1, 65535)),
               (k == 4) ? 24'($urandom) : 24'($urandom_range(0, 65536)));
      queue_random(120, BIAS_NONE);
    end

    wait_idle();
    repeat (CORDIC_ITERS + 10) @(posedge clk);
    if (expected_tilt.size() != 0)
      report_mismatch("results still pending at end", expected_tilt.size(), 0);

    $display("Checked %0d samples over %0d register settings", samples_checked, settings_count);
    $display("Covered every gyro range, zero and full dt, weights 0, one and above one");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ctf_pkg.sv
rtl/ctf_mul.sv
rtl/ctf_cordic.sv
rtl/complementary_tilt_filter_core.sv
test/tb.sv
